[design/lidar_scan_polar_to_xy_frame_diff_macros.svh]
// Assertion macros shared by the checker of the lidar scan converter.
// No dependencies; included by the files that assert.
`ifndef LIDAR_SCAN_POLAR_TO_XY_FRAME_DIFF_MACROS_SVH
`define LIDAR_SCAN_POLAR_TO_XY_FRAME_DIFF_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lidar scan converter: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lidar scan converter: assertion failed");

`endif

[design/lspd_pkg.sv]
// Shared types, constants and the arctangent table of the lidar scan converter.
// No dependencies; imported by the converter, the CORDIC and the point store.
package lspd_pkg;

  // Angle units are 1/64 degree.
  localparam logic signed [15:0] FULL_TURN    = 16'sd23040;
  localparam logic signed [15:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;

  // CORDIC vector and angle widths, 30 fractional bits in the vector.
  localparam int unsigned VEC_W  = 33;
  localparam int unsigned ZW     = 32;
  localparam int unsigned PROD_W = 50;
  localparam logic signed [VEC_W-1:0]  INV_GAIN   = 33'sd652032874;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd536870912;

  // Result saturation in millimetres.
  localparam logic signed [19:0] SAT_POS = 20'sd65535;
  localparam logic signed [19:0] SAT_NEG = -20'sd65535;

  // Register reset value and counter limits.
  localparam logic [10:0] SLOTS_RESET = 11'd800;
  localparam logic [10:0] CNT_MAX     = 11'd2047;
  localparam logic [9:0]  SLOT_OUT_MAX = 10'd1023;

  // One stored point: valid flag, revolution tag and coordinates.
  typedef struct packed {
    logic              valid;
    logic [1:0]        tag;
    logic signed [16:0] x;
    logic signed [16:0] y;
  } lspd_entry_t;

  // Result of one conversion, with a one-cycle done pulse.
  typedef struct packed {
    logic              done;
    logic signed [16:0] x;
    logic signed [16:0] y;
  } lspd_xy_t;

  // Arctangent of 2^-i in 1/64 degree scaled by 2^16.
  function automatic logic [27:0] lspd_atan(input logic [4:0] idx);
    logic [27:0] val;
    case (idx)
      5'd0:    val = 28'd188743680;
      5'd1:    val = 28'd111421900;
      5'd2:    val = 28'd58872272;
      5'd3:    val = 28'd29884485;
      5'd4:    val = 28'd15000234;
      5'd5:    val = 28'd7507429;
      5'd6:    val = 28'd3754631;
      5'd7:    val = 28'd1877430;
      5'd8:    val = 28'd938729;
      5'd9:    val = 28'd469366;
      5'd10:   val = 28'd234683;
      5'd11:   val = 28'd117342;
      5'd12:   val = 28'd58671;
      5'd13:   val = 28'd29335;
      5'd14:   val = 28'd14668;
      5'd15:   val = 28'd7334;
      5'd16:   val = 28'd3667;
      5'd17:   val = 28'd1833;
      5'd18:   val = 28'd917;
      5'd19:   val = 28'd458;
      5'd20:   val = 28'd229;
      5'd21:   val = 28'd115;
      5'd22:   val = 28'd57;
      5'd23:   val = 28'd29;
      default: val = 28'd0;
    endcase
    return val;
  endfunction

endpackage

[design/lspd_cordic.sv]
// Iterative rotation CORDIC with one shared multiplier for range scaling.
// Depends on lspd_pkg for constants, the arctangent table and the result type.
module lspd_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [14:0] angle_i,
  input  logic [15:0]        range_i,
  output lspd_pkg::lspd_xy_t res_o
);
  import lspd_pkg::*;

  localparam int unsigned ITER_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS - 1);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_ROT  = 3'd1;
  localparam logic [2:0] P_MULS = 3'd2;
  localparam logic [2:0] P_MULC = 3'd3;
  localparam logic [2:0] P_RND  = 3'd4;

  logic [2:0]              phase_q, phase_d;
  logic [ITER_W-1:0]       iter_q;
  logic signed [VEC_W-1:0] c_q, s_q;
  logic signed [ZW-1:0]    z_q;
  logic                    neg_q;
  logic [15:0]             r_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [16:0]      x_q, y_q;
  logic                    done_q;

  // Round to whole millimetres (floor of p + 1/2) and saturate.
  function automatic logic signed [16:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] sh;
    logic signed [19:0]       q;
    t  = p + ROUND_HALF;
    sh = t >>> 30;
    q  = sh[19:0];
    if (q > SAT_POS) begin
      q = SAT_POS;
    end else if (q < SAT_NEG) begin
      q = SAT_NEG;
    end
    return q[16:0];
  endfunction

  // Wrap the angle into one turn, then fold it into plus or minus 90 degrees.
  logic signed [15:0] a_ext, a_wrap, a_fold;
  logic               fold_neg;
  always_comb begin
    a_ext = {angle_i[14], angle_i};
    if (a_ext > HALF_TURN) begin
      a_wrap = a_ext - FULL_TURN;
    end else if (a_ext < -HALF_TURN) begin
      a_wrap = a_ext + FULL_TURN;
    end else begin
      a_wrap = a_ext;
    end
    fold_neg = 1'b0;
    if (a_wrap > QUARTER_TURN) begin
      a_fold   = a_wrap - HALF_TURN;
      fold_neg = 1'b1;
    end else if (a_wrap < -QUARTER_TURN) begin
      a_fold   = a_wrap + HALF_TURN;
      fold_neg = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
  end

  // One micro-rotation per cycle through a shared shifter and adders.
  logic signed [VEC_W-1:0] dc, ds;
  logic signed [ZW-1:0]    atan_z;
  assign dc     = s_q >>> iter_q;
  assign ds     = c_q >>> iter_q;
  assign atan_z = $signed({4'd0, lspd_atan(5'(iter_q))});

  // Shared multiplier: sine first, then cosine, sign restored for the far half.
  logic signed [VEC_W-1:0]  mul_sel, mul_v;
  logic signed [PROD_W-1:0] mul_prod;
  assign mul_sel  = (phase_q == P_MULS) ? s_q : c_q;
  assign mul_v    = neg_q ? -mul_sel : mul_sel;
  assign mul_prod = $signed({1'b0, r_q}) * mul_v;

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      P_IDLE: if (start_i) phase_d = P_ROT;
      P_ROT:  if (iter_q == LAST_ITER) phase_d = P_MULS;
      P_MULS: phase_d = P_MULC;
      P_MULC: phase_d = P_RND;
      P_RND:  phase_d = P_IDLE;
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == P_RND);
      if (phase_q == P_ROT) begin
        iter_q <= (iter_q == LAST_ITER) ? '0 : iter_q + 1'b1;
      end else begin
        iter_q <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          c_q   <= INV_GAIN;
          s_q   <= '0;
          z_q   <= {a_fold, 16'd0};
          neg_q <= fold_neg;
          r_q   <= range_i;
        end
      end
      P_ROT: begin
        if (!z_q[ZW-1]) begin
          c_q <= c_q - dc;
          s_q <= s_q + ds;
          z_q <= z_q - atan_z;
        end else begin
          c_q <= c_q + dc;
          s_q <= s_q - ds;
          z_q <= z_q + atan_z;
        end
      end
      P_MULS: prod_q <= mul_prod;
      P_MULC: begin
        x_q    <= round_sat(prod_q);
        prod_q <= mul_prod;
      end
      P_RND: y_q <= round_sat(prod_q);
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.x    = x_q;
  assign res_o.y    = y_q;

endmodule

[design/lspd_store.sv]
// Point store for both revolution banks: one write and one registered read port.
// Depends on lspd_pkg for the entry type.
module lspd_store #(
  parameter int unsigned ADDR_W = 11
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  lspd_pkg::lspd_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output lspd_pkg::lspd_entry_t rdata_o
);
  import lspd_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  lspd_entry_t mem_q [DEPTH];
  lspd_entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/lidar_scan_polar_to_xy_frame_diff.sv]
// An accepted item passes the single CORDIC rotation stage, iterating once per step,
// the shared multiplier and the output register. in_stall_o is held from acceptance
// until the result enters the output register (out_stall_i can delay it): one item at a time.
// Reset clears all control state and the capacity register to 800; the point store
// needs no clearing pass, since only slots below the last revolution length are compared.
module lidar_scan_polar_to_xy_frame_diff #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [14:0] angle_i,
  input  logic [15:0]        range_mm_i,
  input  logic               range_valid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] x_mm_o,
  output logic signed [16:0] y_mm_o,
  output logic               point_ok_o,
  output logic [9:0]         slot_o,
  output logic               overflow_o,
  output logic               revolution_done_o,
  output logic [31:0]        revolution_sad_o,
  output logic [10:0]        pairs_compared_o,
  output logic [15:0]        revolution_number_o
);
  import lspd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned ADDR_W = SLOT_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration and revolution state.
  logic [10:0]        slots_cfg_q;
  logic signed [14:0] prev_angle_q;
  logic               first_q;
  logic [10:0]        slot_index_q;
  logic [31:0]        acc_q;
  logic [10:0]        pair_cnt_q;
  logic [15:0]        rev_cnt_q;
  logic               bank_q;
  logic [1:0]         tag_q;
  logic [10:0]        prev_len_q;

  // Per-item working registers.
  logic              v_q, ovf_q, cmp_ok_q, we_ok_q, done_q;
  logic [10:0]       slot_q;
  logic [ADDR_W-1:0] waddr_q;
  logic [31:0]       sad_cap_q;
  logic [10:0]       pairs_cap_q;
  logic [15:0]       num_cap_q;

  // Output register.
  logic               out_valid_q;
  logic signed [16:0] x_out_q, y_out_q;
  logic               ok_out_q, ovf_out_q, done_out_q;
  logic [9:0]         slot_out_q;
  logic [31:0]        sad_out_q;
  logic [10:0]        pairs_out_q;
  logic [15:0]        num_out_q;

  lspd_xy_t    cordic_res;
  lspd_entry_t rd_entry, wr_entry;

  logic accept, fin_fire;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fin_fire   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Revolution boundary and slot of the incoming item.
  logic              close_now;
  logic [10:0]       slot_now, prev_len_now, slot_next;
  logic              bank_now, ovf_now, in_mem_now;
  logic [31:0]       slot_ext, cap32;
  logic [SLOT_W-1:0] slot_idx;
  always_comb begin
    close_now    = !first_q && (angle_i < prev_angle_q);
    slot_now     = close_now ? 11'd0 : slot_index_q;
    prev_len_now = close_now ? slot_index_q : prev_len_q;
    bank_now     = close_now ? ~bank_q : bank_q;
    slot_ext     = 32'(slot_now);
    slot_idx     = slot_ext[SLOT_W-1:0];
    cap32        = (32'(slots_cfg_q) < MAX_SLOTS) ? 32'(slots_cfg_q) : MAX_SLOTS;
    ovf_now      = slot_ext >= cap32;
    in_mem_now   = slot_ext < MAX_SLOTS;
    slot_next    = (slot_now < CNT_MAX) ? slot_now + 11'd1 : slot_now;
  end

  // Difference against the same slot of the previous revolution.
  logic signed [16:0] x_pt, y_pt;
  logic signed [17:0] dx, dy;
  logic [17:0]        adx, ady;
  logic [33:0]        sum;
  logic               pair;
  always_comb begin
    x_pt = v_q ? cordic_res.x : 17'sd0;
    y_pt = v_q ? cordic_res.y : 17'sd0;
    dx   = {x_pt[16], x_pt} - {rd_entry.x[16], rd_entry.x};
    dy   = {y_pt[16], y_pt} - {rd_entry.y[16], rd_entry.y};
    adx  = dx[17] ? 18'(-dx) : 18'(dx);
    ady  = dy[17] ? 18'(-dy) : 18'(dy);
    sum  = {2'd0, acc_q} + {16'd0, adx} + {16'd0, ady};
    pair = v_q && cmp_ok_q && rd_entry.valid && (rd_entry.tag == tag_q - 2'd1);
    wr_entry.valid = v_q && !ovf_q;
    wr_entry.tag   = tag_q;
    wr_entry.x     = x_pt;
    wr_entry.y     = y_pt;
  end

  // Item sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_CONV;
      S_CONV: if (cordic_res.done) state_d = S_FIN;
      S_FIN:  if (fin_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control and revolution state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slots_cfg_q  <= SLOTS_RESET;
      prev_angle_q <= '0;
      first_q      <= 1'b1;
      slot_index_q <= '0;
      acc_q        <= '0;
      pair_cnt_q   <= '0;
      rev_cnt_q    <= '0;
      bank_q       <= 1'b0;
      tag_q        <= '0;
      prev_len_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        slots_cfg_q <= cfg_wdata_i;
      end
      if (accept) begin
        first_q      <= 1'b0;
        prev_angle_q <= angle_i;
        slot_index_q <= slot_next;
        prev_len_q   <= prev_len_now;
        bank_q       <= bank_now;
        if (close_now) begin
          acc_q      <= '0;
          pair_cnt_q <= '0;
          rev_cnt_q  <= rev_cnt_q + 16'd1;
          tag_q      <= tag_q + 2'd1;
        end
      end
      if (fin_fire && pair) begin
        acc_q <= sum[33:32] != 2'd0 ? 32'hFFFF_FFFF : sum[31:0];
        if (pair_cnt_q < CNT_MAX) begin
          pair_cnt_q <= pair_cnt_q + 11'd1;
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-item payload captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q         <= range_valid_i;
      slot_q      <= slot_now;
      ovf_q       <= ovf_now;
      cmp_ok_q    <= !ovf_now && (slot_now < prev_len_now);
      we_ok_q     <= !ovf_now || in_mem_now;
      waddr_q     <= {bank_now, slot_idx};
      done_q      <= close_now;
      sad_cap_q   <= close_now ? acc_q : 32'd0;
      pairs_cap_q <= close_now ? pair_cnt_q : 11'd0;
      num_cap_q   <= close_now ? rev_cnt_q + 16'd1 : 16'd0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      x_out_q     <= x_pt;
      y_out_q     <= y_pt;
      ok_out_q    <= v_q;
      slot_out_q  <= (slot_q > 11'(SLOT_OUT_MAX)) ? SLOT_OUT_MAX : slot_q[9:0];
      ovf_out_q   <= ovf_q;
      done_out_q  <= done_q;
      sad_out_q   <= sad_cap_q;
      pairs_out_q <= pairs_cap_q;
      num_out_q   <= num_cap_q;
    end
  end

  lspd_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .angle_i (angle_i),
    .range_i (range_mm_i),
    .res_o   (cordic_res)
  );

  lspd_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (fin_fire && we_ok_q),
    .waddr_i (waddr_q),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i ({~bank_now, slot_idx}),
    .rdata_o (rd_entry)
  );

  assign out_valid_o         = out_valid_q;
  assign x_mm_o              = x_out_q;
  assign y_mm_o              = y_out_q;
  assign point_ok_o          = ok_out_q;
  assign slot_o              = slot_out_q;
  assign overflow_o          = ovf_out_q;
  assign revolution_done_o   = done_out_q;
  assign revolution_sad_o    = sad_out_q;
  assign pairs_compared_o    = pairs_out_q;
  assign revolution_number_o = num_out_q;

endmodule

[design/lspd_checker.sv]
// Port-level checks of the lidar scan converter, bound to its top level.
// Depends on the assertion macros header.
`include "lidar_scan_polar_to_xy_frame_diff_macros.svh"

module lspd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [16:0] x_mm_o,
  input logic signed [16:0] y_mm_o,
  input logic               point_ok_o,
  input logic               revolution_done_o,
  input logic [31:0]        revolution_sad_o,
  input logic [10:0]        pairs_compared_o,
  input logic [15:0]        revolution_number_o
);

  // A stalled result item holds its value.
  `LSPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(x_mm_o) && $stable(y_mm_o) && $stable(revolution_sad_o))

  // The converter works on one item at a time.
  `LSPD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // An invalid return yields a zero point.
  `LSPD_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_o && !point_ok_o, x_mm_o == 17'sd0 && y_mm_o == 17'sd0)

  // Revolution figures are zero unless the item closed a revolution.
  `LSPD_ASSERT_IMP(a_rev_fields_zero, clk_i, rst_ni, out_valid_o && !revolution_done_o, revolution_sad_o == 32'd0 && pairs_compared_o == 11'd0 && revolution_number_o == 16'd0)

endmodule

bind lidar_scan_polar_to_xy_frame_diff lspd_checker u_lspd_checker (.*);
